// ----- design/robin_hood_hash_table_core_macros.svh -----
// assertion macros shared by the robin hood hash table rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ROBIN_HOOD_HASH_TABLE_CORE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_CORE_MACROS_SVH

// expression must hold at every edge out of reset
`define RHH_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must hold in the cycle of the antecedent
`define RHH_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/rhh_pkg.sv -----
// types, codes and fixed widths of the robin hood hash table
// no dependencies
`default_nettype none

package rhh_pkg;

  localparam int unsigned SLOTS    = 1024;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned OCC_W    = 11;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CFG_W-1:0] RESET_SIZE = 11'd13;
  localparam logic [CFG_W-1:0] MIN_SIZE   = 11'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_KEY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_CLEAR,
    OP_REJECT,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } job_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_MOD,
    B_RD,
    B_EV,
    B_FIN
  } back_state_e;

endpackage

`default_nettype wire

// ----- design/rhh_ifs.sv -----
// request, response and configuration channels of the hash table
// depends on rhh_pkg
`default_nettype none

interface rhh_req_if;
  logic                           valid;
  logic                           ready;
  logic [rhh_pkg::CMD_W-1:0]      cmd;
  logic [rhh_pkg::KEY_W-1:0]      key;
  logic [rhh_pkg::HASH_W-1:0]     hash_value;
  modport source (output valid, cmd, key, hash_value, input ready);
  modport sink (input valid, cmd, key, hash_value, output ready);
endinterface

interface rhh_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic                           replaced;
  logic [rhh_pkg::STATUS_W-1:0]   status;
  logic [rhh_pkg::KEY_W-1:0]      found_key;
  logic [rhh_pkg::SLOT_W-1:0]     found_slot;
  logic [rhh_pkg::OCC_W-1:0]      occupied;
  modport source (output valid, hit, replaced, status, found_key, found_slot, occupied,
                  input ready);
  modport sink (input valid, hit, replaced, status, found_key, found_slot, occupied,
                output ready);
endinterface

interface rhh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rhh_pkg::CFG_W-1:0]      data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/rhh_front.sv -----
// front end: takes request words, masks the key, classifies the command
// and holds jobs in a two-entry queue; depends on rhh_pkg and rhh_ifs
`default_nettype none

module rhh_front #(
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  rhh_req_if.sink        req,
  output rhh_pkg::job_t  job_o,
  output logic           job_valid_o,
  input  wire logic      job_ready_i
);

  localparam logic [1:0] QDEPTH = 2'd2;

  rhh_pkg::job_t             queue_q [2];
  logic                      wr_ptr_q, wr_ptr_d;
  logic                      rd_ptr_q, rd_ptr_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [rhh_pkg::KEY_W-1:0] key_mask;
  logic [rhh_pkg::KEY_W-1:0] key_m;
  rhh_pkg::job_t             job_in;
  logic                      push, pop;

  assign key_mask = rhh_pkg::KEY_W'({KEY_BITS{1'b1}});
  assign key_m    = req.key & key_mask;

  always_comb begin
    job_in.key  = key_m;
    job_in.hash = req.hash_value;
    case (req.cmd)
      rhh_pkg::CMD_INSERT: begin
        job_in.op = (key_m == '0) ? rhh_pkg::OP_REJECT : rhh_pkg::OP_INSERT;
      end
      rhh_pkg::CMD_LOOKUP: begin
        job_in.op = (key_m == '0) ? rhh_pkg::OP_REJECT : rhh_pkg::OP_LOOKUP;
      end
      rhh_pkg::CMD_CLEAR: begin
        job_in.op = rhh_pkg::OP_CLEAR;
      end
      default: begin
        job_in.op = rhh_pkg::OP_NOP;
      end
    endcase
  end

  assign req.ready   = (cnt_q != QDEPTH);
  assign push        = req.valid && req.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/rhh_mod.sv -----
// bit-serial remainder of the 64-bit hash by the table size, one bit a cycle
// depends on rhh_pkg
`default_nettype none

module rhh_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rhh_pkg::HASH_W-1:0]  dividend_i,
  input  wire logic [rhh_pkg::CFG_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rhh_pkg::CFG_W-1:0]        rem_o
);

  localparam int unsigned CNT_W = $clog2(rhh_pkg::HASH_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(rhh_pkg::HASH_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [rhh_pkg::HASH_W-1:0]  sh_q, sh_d;
  logic [rhh_pkg::CFG_W-1:0]   rem_q, rem_d;
  logic [rhh_pkg::CFG_W:0]     trial;

  assign trial = {rem_q, sh_q[rhh_pkg::HASH_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[rhh_pkg::HASH_W-2:0], 1'b0};
      // restoring step, remainder stays below the divisor
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = rhh_pkg::CFG_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[rhh_pkg::CFG_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- design/rhh_back.sv -----
// back end: slot memory, probe walk sequencer and response register
// depends on rhh_pkg, rhh_ifs, rhh_mod and the macros header
`default_nettype none
`include "robin_hood_hash_table_core_macros.svh"

module rhh_back #(
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rhh_pkg::job_t              job_i,
  input  wire logic                       job_valid_i,
  output logic                            job_ready_o,
  input  wire logic [rhh_pkg::CFG_W-1:0]  size_i,
  rhh_rsp_if.source                       rsp
);

  localparam int unsigned SLOTS = rhh_pkg::SLOTS;
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] DMAX      = {IW{1'b1}};
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef struct packed {
    logic                valid;
    logic [IW-1:0]       pdist;
    logic [KEY_BITS-1:0] key;
  } slot_t;

  rhh_pkg::back_state_e state_q, state_d;

  slot_t mem_q [SLOTS];
  slot_t rdata_q;
  slot_t wdata;
  logic  we, re;
  logic [IW-1:0] waddr, raddr;

  logic [rhh_pkg::CFG_W-1:0] n;
  logic                      mod_start, mod_done;
  logic [rhh_pkg::CFG_W-1:0] mod_rem;
  logic                      mod_go_q;

  logic [IW-1:0]             sweep_q, sweep_d;
  logic                      clr_rsp_q, clr_rsp_d;
  rhh_pkg::op_e              op_q, op_d;
  logic                      dry_q, dry_d;
  logic [KEY_BITS-1:0]       key_q, key_d;
  logic [rhh_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [IW-1:0]             home_q, home_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic [IW-1:0]             d_q, d_d;
  logic [KEY_BITS-1:0]       carry_q, carry_d;
  logic [rhh_pkg::CFG_W-1:0] step_q, step_d;
  logic                      moved_q, moved_d;
  logic [IW-1:0]             placed_q, placed_d;
  logic [NW-1:0]             count_q, count_d;

  logic                      hit_q, hit_d;
  logic                      repl_q, repl_d;
  rhh_pkg::status_e          status_q, status_d;
  logic [KEY_BITS-1:0]       fkey_q, fkey_d;
  logic [IW-1:0]             fslot_q, fslot_d;

  logic                      ov_q, ov_d;
  logic                      o_hit_q, o_hit_d;
  logic                      o_repl_q, o_repl_d;
  rhh_pkg::status_e          o_status_q, o_status_d;
  logic [rhh_pkg::KEY_W-1:0] o_fkey_q, o_fkey_d;
  logic [rhh_pkg::SLOT_W-1:0] o_fslot_q, o_fslot_d;
  logic [rhh_pkg::OCC_W-1:0] o_occ_q, o_occ_d;

  logic          load_out;
  logic          ev_finish;
  logic [IW-1:0] nxt_idx;
  logic          last_step;
  logic [IW-1:0] dnew;

  // effective size, clamped to [2, SLOTS]
  always_comb begin
    if (size_i < rhh_pkg::MIN_SIZE) begin
      n = rhh_pkg::MIN_SIZE;
    end else if (32'(size_i) > SLOTS) begin
      n = rhh_pkg::CFG_W'(SLOTS);
    end else begin
      n = size_i;
    end
  end

  rhh_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (hash_q),
    .divisor_i  (n),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign nxt_idx   = (32'(idx_q) + 32'd1 == 32'(n)) ? '0 : idx_q + 1'b1;
  assign last_step = (step_q + 1'b1) == n;

  // datapath and control outputs
  always_comb begin
    sweep_d   = sweep_q;
    clr_rsp_d = clr_rsp_q;
    op_d      = op_q;
    dry_d     = dry_q;
    key_d     = key_q;
    hash_d    = hash_q;
    home_d    = home_q;
    idx_d     = idx_q;
    d_d       = d_q;
    carry_d   = carry_q;
    step_d    = step_q;
    moved_d   = moved_q;
    placed_d  = placed_q;
    count_d   = count_q;
    hit_d     = hit_q;
    repl_d    = repl_q;
    status_d  = status_q;
    fkey_d    = fkey_q;
    fslot_d   = fslot_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_q;
    raddr     = idx_q;
    wdata     = '{valid: 1'b1, pdist: d_q, key: carry_q};
    mod_start = 1'b0;
    job_ready_o = 1'b0;
    load_out  = 1'b0;
    ev_finish = 1'b0;
    dnew      = d_q;
    case (state_q)
      rhh_pkg::B_SWEEP: begin
        we      = 1'b1;
        waddr   = sweep_q;
        wdata   = '0;
        sweep_d = sweep_q + 1'b1;
        count_d = '0;
      end
      rhh_pkg::B_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          op_d     = job_i.op;
          key_d    = KEY_BITS'(job_i.key);
          hash_d   = job_i.hash;
          dry_d    = 1'b1;
          hit_d    = 1'b0;
          repl_d   = 1'b0;
          status_d = rhh_pkg::ST_OK;
          fkey_d   = '0;
          fslot_d  = '0;
          case (job_i.op)
            rhh_pkg::OP_CLEAR: begin
              sweep_d   = '0;
              clr_rsp_d = 1'b1;
            end
            rhh_pkg::OP_REJECT: begin
              status_d = rhh_pkg::ST_ZERO_KEY;
            end
            default: begin
            end
          endcase
        end
      end
      rhh_pkg::B_MOD: begin
        // divider is started on the first mod cycle, once the hash is latched
        mod_start = mod_go_q;
        if (mod_done) begin
          home_d   = IW'(mod_rem);
          idx_d    = IW'(mod_rem);
          d_d      = '0;
          carry_d  = key_q;
          step_d   = '0;
          moved_d  = 1'b0;
          placed_d = '0;
        end
      end
      rhh_pkg::B_RD: begin
        re = 1'b1;
      end
      rhh_pkg::B_EV: begin
        if (op_q == rhh_pkg::OP_INSERT) begin
          if (!rdata_q.valid || rdata_q.key == carry_q) begin
            if (dry_q) begin
              // dry run found room, walk again and commit
              dry_d    = 1'b0;
              idx_d    = home_q;
              d_d      = '0;
              carry_d  = key_q;
              step_d   = '0;
              moved_d  = 1'b0;
              placed_d = '0;
            end else begin
              ev_finish = 1'b1;
              fslot_d   = moved_q ? placed_q : idx_q;
              if (!rdata_q.valid) begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                repl_d = !moved_q;
              end
            end
          end else begin
            if (d_q > rdata_q.pdist) begin
              // rich resident gives up its slot to the carried key
              we      = !dry_q;
              carry_d = rdata_q.key;
              dnew    = rdata_q.pdist;
              if (!moved_q) begin
                placed_d = idx_q;
                moved_d  = 1'b1;
              end
            end
            d_d    = (dnew == DMAX) ? dnew : dnew + 1'b1;
            idx_d  = nxt_idx;
            step_d = step_q + 1'b1;
            if (last_step) begin
              ev_finish = 1'b1;
              status_d  = rhh_pkg::ST_FULL;
            end
          end
        end else begin
          if (!rdata_q.valid) begin
            ev_finish = 1'b1;
          end else if (rdata_q.key == key_q) begin
            ev_finish = 1'b1;
            hit_d     = 1'b1;
            fkey_d    = rdata_q.key;
            fslot_d   = idx_q;
          end else if (rdata_q.pdist < d_q) begin
            ev_finish = 1'b1;
          end else begin
            d_d    = (d_q == DMAX) ? d_q : d_q + 1'b1;
            idx_d  = nxt_idx;
            step_d = step_q + 1'b1;
            ev_finish = last_step;
          end
        end
      end
      rhh_pkg::B_FIN: begin
        if (!ov_q || rsp.ready) begin
          load_out  = 1'b1;
          clr_rsp_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // the divider starts from the latched hash on the first mod cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_go_q <= 1'b0;
    end else begin
      mod_go_q <= (state_q == rhh_pkg::B_IDLE) && job_valid_i &&
                  (job_i.op == rhh_pkg::OP_INSERT || job_i.op == rhh_pkg::OP_LOOKUP);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rhh_pkg::B_SWEEP: begin
        if (sweep_q == LAST_SLOT) begin
          state_d = clr_rsp_q ? rhh_pkg::B_FIN : rhh_pkg::B_IDLE;
        end
      end
      rhh_pkg::B_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            rhh_pkg::OP_INSERT, rhh_pkg::OP_LOOKUP: state_d = rhh_pkg::B_MOD;
            rhh_pkg::OP_CLEAR:                       state_d = rhh_pkg::B_SWEEP;
            default:                                 state_d = rhh_pkg::B_FIN;
          endcase
        end
      end
      rhh_pkg::B_MOD: begin
        if (mod_done) begin
          state_d = rhh_pkg::B_RD;
        end
      end
      rhh_pkg::B_RD: begin
        state_d = rhh_pkg::B_EV;
      end
      rhh_pkg::B_EV: begin
        state_d = ev_finish ? rhh_pkg::B_FIN : rhh_pkg::B_RD;
      end
      rhh_pkg::B_FIN: begin
        if (load_out) begin
          state_d = rhh_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = rhh_pkg::B_IDLE;
      end
    endcase
  end

  // response register
  always_comb begin
    ov_d       = ov_q;
    o_hit_d    = o_hit_q;
    o_repl_d   = o_repl_q;
    o_status_d = o_status_q;
    o_fkey_d   = o_fkey_q;
    o_fslot_d  = o_fslot_q;
    o_occ_d    = o_occ_q;
    if (load_out) begin
      ov_d       = 1'b1;
      o_hit_d    = hit_q;
      o_repl_d   = repl_q;
      o_status_d = status_q;
      o_fkey_d   = rhh_pkg::KEY_W'(fkey_q);
      o_fslot_d  = rhh_pkg::SLOT_W'(fslot_q);
      o_occ_d    = rhh_pkg::OCC_W'(count_q);
    end else if (rsp.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rhh_pkg::B_SWEEP;
      sweep_q   <= '0;
      clr_rsp_q <= 1'b0;
      count_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      clr_rsp_q <= clr_rsp_d;
      count_q   <= count_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    dry_q      <= dry_d;
    key_q      <= key_d;
    hash_q     <= hash_d;
    home_q     <= home_d;
    idx_q      <= idx_d;
    d_q        <= d_d;
    carry_q    <= carry_d;
    step_q     <= step_d;
    moved_q    <= moved_d;
    placed_q   <= placed_d;
    hit_q      <= hit_d;
    repl_q     <= repl_d;
    status_q   <= status_d;
    fkey_q     <= fkey_d;
    fslot_q    <= fslot_d;
    o_hit_q    <= o_hit_d;
    o_repl_q   <= o_repl_d;
    o_status_q <= o_status_d;
    o_fkey_q   <= o_fkey_d;
    o_fslot_q  <= o_fslot_d;
    o_occ_q    <= o_occ_d;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rsp.valid      = ov_q;
  assign rsp.hit        = o_hit_q;
  assign rsp.replaced   = o_repl_q;
  assign rsp.status     = o_status_q;
  assign rsp.found_key  = o_fkey_q;
  assign rsp.found_slot = o_fslot_q;
  assign rsp.occupied   = o_occ_q;

  `RHH_ASSERT(a_count_max, count_q <= NW'(SLOTS), "entry count above slot count")
  `RHH_IMPLIES(a_ev_after_rd, state_q == rhh_pkg::B_EV, $past(state_q) == rhh_pkg::B_RD, "probe evaluated without a read")
  `RHH_IMPLIES(a_dry_no_write, we && state_q == rhh_pkg::B_EV, !dry_q, "dry run wrote the table")
  `RHH_IMPLIES(a_mod_in_mod, mod_done, state_q == rhh_pkg::B_MOD, "home slot ready outside mod state")

endmodule

`default_nettype wire

// ----- design/robin_hood_hash_table_core.sv -----
// robin hood hash table, top level: size register, front end and back end
// Channels: req (cmd, key, hash_value), rsp (one word per request) and cfg,
// which writes table_size; all move a word when valid and ready are high.
// cfg is always ready and may be written only while no request is in flight.
// After reset the back end clears the slot memory, one slot a cycle, through
// all SLOTS (1024) slots; requests are queued but not served until that sweep ends.
// The front end takes a request word in any cycle its two-entry queue has
// room, even while a response waits in the output register.
// Insert and lookup first form the home slot (serial remainder, one hash bit
// a cycle), then walk probe steps, each a read (B_RD) and an evaluation (B_EV)
// of one slot; an insert that finds room walks twice (a dry run, then the committed walk).
// Clear sweeps the memory before it answers; a rejected zero key or unknown
// command answers without a probe walk.
// A stalled rsp holds its word; the back end then waits with its next result.
// depends on rhh_pkg, rhh_ifs, rhh_front, rhh_back
`default_nettype none

module robin_hood_hash_table_core #(
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rhh_req_if.sink    req,
  rhh_rsp_if.source  rsp,
  rhh_cfg_if.sink    cfg
);

  logic [rhh_pkg::CFG_W-1:0] size_q, size_d;
  rhh_pkg::job_t             job;
  logic                      job_valid;
  logic                      job_ready;

  assign cfg.ready = 1'b1;
  assign size_d    = (cfg.valid && cfg.ready) ? cfg.data : size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= rhh_pkg::RESET_SIZE;
    end else begin
      size_q <= size_d;
    end
  end

  rhh_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  rhh_back #(
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .size_i      (size_q),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

// ----- dv/robin_hood_hash_table_core_test.sv -----
// self-checking testbench for robin_hood_hash_table_core: directed and random requests
// scored against a behavioral robin hood table; depends on rhh_pkg, rhh_ifs and the core
`default_nettype none

module robin_hood_hash_table_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS      = rhh_pkg::SLOTS;
  localparam int unsigned DIST_MAX   = SLOTS - 1;
  localparam int unsigned IDLE_LIMIT = 50000;
  localparam int unsigned POOL_N     = 64;

  typedef struct {
    logic                         hit;
    logic                         replaced;
    logic [rhh_pkg::STATUS_W-1:0] status;
    logic [rhh_pkg::KEY_W-1:0]    found_key;
    logic [rhh_pkg::SLOT_W-1:0]   found_slot;
    logic [rhh_pkg::OCC_W-1:0]    occupied;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rhh_req_if req_if ();
  rhh_rsp_if rsp_if ();
  rhh_cfg_if cfg_if ();

  robin_hood_hash_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // behavioral copy of the table
  logic                       table_valid [SLOTS];
  logic [rhh_pkg::SLOT_W-1:0] table_dist  [SLOTS];
  logic [rhh_pkg::KEY_W-1:0]  table_key   [SLOTS];
  int unsigned                table_count;
  logic [rhh_pkg::CFG_W-1:0]  table_size_q;

  answer_t     pending_answers [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          no_gaps;

  logic [rhh_pkg::KEY_W-1:0]  key_pool  [POOL_N];
  logic [rhh_pkg::HASH_W-1:0] hash_pool [POOL_N];

  function automatic int unsigned effective_size();
    int unsigned t;
    t = table_size_q;
    if (t < 2) t = 2;
    if (t > SLOTS) t = SLOTS;
    return t;
  endfunction

  // 0 full, 1 filled empty slot, 2 met equal key
  function automatic int probe_insert(input logic [rhh_pkg::KEY_W-1:0] key,
                                      input int unsigned home,
                                      input int unsigned n, input bit commit,
                                      output int unsigned placed, output bit moved);
    int unsigned idx;
    int unsigned d;
    logic [rhh_pkg::KEY_W-1:0] carry;
    logic [rhh_pkg::KEY_W-1:0] tk;
    int unsigned td;
    idx = home;
    d = 0;
    carry = key;
    placed = 0;
    moved = 0;
    for (int unsigned step = 0; step < n; step++) begin
      if (!table_valid[idx]) begin
        if (commit) begin
          table_valid[idx] = 1'b1;
          table_dist[idx] = d;
          table_key[idx] = carry;
          table_count++;
        end
        if (!moved) placed = idx;
        return 1;
      end
      if (table_key[idx] == carry) begin
        if (!moved) placed = idx;
        return 2;
      end
      if (d > table_dist[idx]) begin
        tk = table_key[idx];
        td = table_dist[idx];
        if (!moved) begin
          placed = idx;
          moved = 1;
        end
        if (commit) begin
          table_key[idx] = carry;
          table_dist[idx] = d;
        end
        carry = tk;
        d = td;
      end
      idx = (idx + 1 == n) ? 0 : idx + 1;
      if (d < DIST_MAX) d++;
    end
    return 0;
  endfunction

  function automatic answer_t predict_request(input rhh_pkg::cmd_e cmd,
                                              input logic [rhh_pkg::KEY_W-1:0] key,
                                              input logic [rhh_pkg::HASH_W-1:0] hash);
    answer_t a;
    int unsigned n;
    int unsigned home;
    int unsigned placed;
    int unsigned idx;
    int unsigned d;
    bit moved;
    int rc;
    a = '{default: '0};
    n = effective_size();
    home = hash % n;
    if (cmd == rhh_pkg::CMD_CLEAR) begin
      foreach (table_valid[i]) begin
        table_valid[i] = 1'b0;
        table_dist[i] = '0;
      end
      table_count = 0;
    end else if ((cmd == rhh_pkg::CMD_INSERT || cmd == rhh_pkg::CMD_LOOKUP) && key == '0) begin
      a.status = rhh_pkg::ST_ZERO_KEY;
    end else if (cmd == rhh_pkg::CMD_INSERT) begin
      rc = probe_insert(key, home, n, 1'b0, placed, moved);
      if (rc == 0) begin
        a.status = rhh_pkg::ST_FULL;
      end else begin
        rc = probe_insert(key, home, n, 1'b1, placed, moved);
        a.replaced = (rc == 2) && !moved;
        a.found_slot = placed;
      end
    end else if (cmd == rhh_pkg::CMD_LOOKUP) begin
      idx = home;
      d = 0;
      for (int unsigned step = 0; step < n && table_valid[idx]; step++) begin
        if (table_key[idx] == key) begin
          a.hit = 1'b1;
          a.found_key = table_key[idx];
          a.found_slot = idx;
          break;
        end
        if (table_dist[idx] < d) break;
        idx = (idx + 1 == n) ? 0 : idx + 1;
        if (d < DIST_MAX) d++;
      end
    end
    a.occupied = table_count;
    return a;
  endfunction

  task automatic send_request(input rhh_pkg::cmd_e cmd,
                              input logic [rhh_pkg::KEY_W-1:0] key,
                              input logic [rhh_pkg::HASH_W-1:0] hash);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.cmd = cmd;
    req_if.key = key;
    req_if.hash_value = hash;
    do @(posedge clk_i); while (!req_if.ready);
    pending_answers.push_back(predict_request(cmd, key, hash));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [rhh_pkg::CFG_W-1:0] size);
    wait_drained();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = size;
    do @(posedge clk_i); while (!cfg_if.ready);
    table_size_q = size;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // each pool key keeps a fixed hash, so repeats hit and collide
  task automatic send_random(input int unsigned count);
    int unsigned r;
    int unsigned p;
    rhh_pkg::cmd_e cmd;
    logic [rhh_pkg::KEY_W-1:0] key;
    logic [rhh_pkg::HASH_W-1:0] hash;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      cmd = (r < 55) ? rhh_pkg::CMD_INSERT : (r < 95) ? rhh_pkg::CMD_LOOKUP :
            (r < 98) ? rhh_pkg::CMD_CLEAR : rhh_pkg::CMD_NONE;
      p = $urandom_range(0, POOL_N - 1);
      key = key_pool[p];
      hash = hash_pool[p];
      r = $urandom_range(0, 99);
      if (r < 3) key = '0;
      else if (r < 18) key = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) hash = {$urandom, $urandom};
      send_request(cmd, key, hash);
    end
  endtask

  task automatic test_directed();
    send_request(rhh_pkg::CMD_INSERT, '0, 64'd5);
    send_request(rhh_pkg::CMD_LOOKUP, '0, 64'd5);
    send_request(rhh_pkg::CMD_LOOKUP, 64'd77, 64'd3);
    send_request(rhh_pkg::CMD_INSERT, '1, '1);
    send_request(rhh_pkg::CMD_INSERT, 64'd1, '0);
    send_request(rhh_pkg::CMD_INSERT, '1, '1);
    send_request(rhh_pkg::CMD_LOOKUP, '1, '1);
    // same home: chain builds, then a far key steals a slot
    send_request(rhh_pkg::CMD_INSERT, 64'h11, 64'd4);
    send_request(rhh_pkg::CMD_INSERT, 64'h22, 64'd4);
    send_request(rhh_pkg::CMD_INSERT, 64'h33, 64'd4);
    send_request(rhh_pkg::CMD_INSERT, 64'h44, 64'd5);
    send_request(rhh_pkg::CMD_INSERT, 64'h55, 64'd4);
    send_request(rhh_pkg::CMD_LOOKUP, 64'h44, 64'd5);
    send_request(rhh_pkg::CMD_LOOKUP, 64'h66, 64'd4);
    send_request(rhh_pkg::CMD_NONE, 64'h11, 64'd4);
    send_request(rhh_pkg::CMD_CLEAR, '1, '1);
    send_request(rhh_pkg::CMD_LOOKUP, 64'h11, 64'd4);
    write_size(11'd0);
    send_request(rhh_pkg::CMD_INSERT, 64'hA, 64'd0);
    send_request(rhh_pkg::CMD_INSERT, 64'hB, 64'd1);
    send_request(rhh_pkg::CMD_INSERT, 64'hC, 64'd1);
    send_request(rhh_pkg::CMD_INSERT, 64'hA, 64'd1);
    send_request(rhh_pkg::CMD_LOOKUP, 64'hC, 64'd0);
    send_request(rhh_pkg::CMD_CLEAR, '0, '0);
  endtask

  // shrink without clearing, then regrow, so displaced keys meet equal ones
  task automatic test_size_changes();
    write_size(11'd16);
    send_random(250);
    write_size(11'd5);
    send_random(150);
    write_size(11'd1);
    send_random(60);
    write_size(11'd31);
    send_random(300);
    write_size(11'd2047);
    send_random(30);
    write_size(11'd1024);
    send_random(30);
    write_size(11'd7);
    send_random(200);
    write_size(11'd64);
    send_random(300);
    write_size(11'd3);
    send_random(120);
  endtask

  task automatic test_back_to_back();
    write_size(11'd24);
    no_gaps = 1;
    send_random(150);
    no_gaps = 0;
  endtask

  task automatic test_drain_pause();
    write_size(11'd13);
    send_random(100);
    wait_drained();
    send_random(100);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = rhh_pkg::CMD_NONE;
    req_if.key = '0;
    req_if.hash_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = rhh_pkg::RESET_SIZE;
    mismatches = 0;
    no_gaps = 0;
    foreach (table_valid[i]) begin
      table_valid[i] = 1'b0;
      table_dist[i] = '0;
      table_key[i] = '0;
    end
    table_count = 0;
    table_size_q = rhh_pkg::RESET_SIZE;
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom} | 64'd1;
      hash_pool[i] = {$urandom, $urandom};
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_size_changes();
    test_back_to_back();
    test_drain_pause();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side holds ready low at random before each word unless no_gaps is set
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!(rst_ni && rsp_if.valid));
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, occupied %0d", rsp_if.occupied);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.hit !== want.hit || rsp_if.replaced !== want.replaced ||
            rsp_if.status !== want.status || rsp_if.found_key !== want.found_key ||
            rsp_if.found_slot !== want.found_slot || rsp_if.occupied !== want.occupied) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %0b rep %0b st %0d key %h slot %0d occ %0d, got hit %0b rep %0b st %0d key %h slot %0d occ %0d",
                     want.hit, want.replaced, want.status, want.found_key, want.found_slot,
                     want.occupied, rsp_if.hit, rsp_if.replaced, rsp_if.status,
                     rsp_if.found_key, rsp_if.found_slot, rsp_if.occupied);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/rhh_pkg.sv
design/rhh_ifs.sv
design/rhh_front.sv
design/rhh_mod.sv
design/rhh_back.sv
design/robin_hood_hash_table_core.sv
dv/robin_hood_hash_table_core_test.sv
